// File: rtl/acmcp_pkg.sv
`default_nettype none

package acmcp_pkg;

    localparam logic [31:0] ARC_MAGIC      = 32'h8c13_5d65;
    localparam logic [31:0] FMT_GEN1       = 32'h0001_0108;
    localparam logic [31:0] FMT_GEN3       = 32'h0003_0108;
    localparam logic [7:0]  ARC_HDR_LEN    = 8'd13;
    localparam logic [32:0] ARC_HDR_START  = 33'd13;
    localparam logic [7:0]  MAGIC_LAST     = 8'd4;
    localparam logic [7:0]  FORMAT_LAST    = 8'd8;
    localparam logic [7:0]  VARIANT_POS    = 8'd9;
    localparam logic [7:0]  MH_FLAG_POS    = 8'd0;
    localparam logic [7:0]  MH_SIZE_LAST   = 8'd4;
    localparam logic [7:0]  MH_LINK_LAST   = 8'd8;
    localparam logic [7:0]  MH_DATE_FIRST  = 8'd9;
    localparam logic [7:0]  MH_DATE_LAST   = 8'd12;
    localparam logic [7:0]  MHDR_GEN1_LAST = 8'd11;
    localparam logic [7:0]  MHDR_GEN3_LAST = 8'd15;
    localparam logic [7:0]  NAME_MIN       = 8'h20;
    localparam logic [7:0]  VARIANT_ONE    = 8'd1;
    localparam logic [7:0]  VARIANT_TWO    = 8'd2;
    localparam logic [12:0] MAX_MEMBERS    = 13'd4096;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    typedef enum logic [2:0] {
        PH_ARC,
        PH_MHDR,
        PH_NAME,
        PH_SEP,
        PH_PAY,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ARC    = 3'd1,
        ST_BAD_MEMBER = 3'd2,
        ST_CHAIN      = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_TRAILING   = 3'd5,
        ST_TOO_MANY   = 3'd6
    } status_t;

    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [12:0] member_index;
        logic [32:0] hdr_offset;
        logic [32:0] pay_offset;
        logic [30:0] pay_size;
        logic [7:0]  member_flags;
        logic [7:0]  name_bytes;
        logic [15:0] stamp_date;
        logic [15:0] stamp_time;
        logic        gen_three;
        logic [1:0]  variant;
    } result_t;

    typedef struct packed {
        logic rec_valid;
        logic fin_valid;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/acmcp_outq.sv
`default_nettype none

module acmcp_outq import acmcp_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    input  wire result_t rec,
    input  wire result_t fin,
    output logic         space_two,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    localparam int CNT_W = OUTQ_PTR_W + 1;

    result_t               slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_reg;
    logic [OUTQ_PTR_W-1:0] wr_next;
    logic [OUTQ_PTR_W-1:0] rd_reg;
    logic [OUTQ_PTR_W-1:0] rd_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      push_n;
    logic                  pop;

    assign push_n    = CNT_W'(push.rec_valid) + CNT_W'(push.fin_valid);
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign head      = slot_reg[rd_reg];
    assign space_two = (count_reg <= CNT_W'(OUTQ_DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + OUTQ_PTR_W'(push_n);
        rd_next    = pop ? rd_reg + OUTQ_PTR_W'(1) : rd_reg;
        count_next = count_reg + push_n - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.rec_valid)
        begin
            slot_reg[wr_reg] <= rec;
            if (push.fin_valid)
            begin
                slot_reg[wr_reg + OUTQ_PTR_W'(1)] <= fin;
            end
        end
        else if (push.fin_valid)
        begin
            slot_reg[wr_reg] <= fin;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(OUTQ_DEPTH))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != '0) |-> ((count_reg + push_n) <= CNT_W'(OUTQ_DEPTH)))
        else $error("push into full output queue");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == '0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("output queue count did not drop on transfer");

endmodule

`default_nettype wire

// File: rtl/archive_member_chain_parser.sv
`default_nettype none
// path: a result passes the input register, then the output queue, before it is valid at the
// outputs and can be transferred; a full output queue holds the byte in the input register
// throughput: one byte per cycle; input stalls while more than two results wait in the
// 4-entry output queue, a byte can give both a member record and the final status
// reset: rst_n asynchronous active low, parser returns to archive header phase, base_offset 0
// the parser also restarts by itself after each final byte

module archive_member_chain_parser import acmcp_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_final,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [2:0]       status,
    output logic [12:0]      member_index,
    output logic [32:0]      hdr_offset,
    output logic [32:0]      pay_offset,
    output logic [30:0]      pay_size,
    output logic [7:0]       member_flags,
    output logic [7:0]       name_bytes,
    output logic [15:0]      stamp_date,
    output logic [15:0]      stamp_time,
    output logic             gen_three,
    output logic [1:0]       variant
);

    logic [31:0] base_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        final_reg;

    phase_t      phase_reg,  phase_next;
    status_t     err_reg,    err_next;
    logic [7:0]  fc_reg,     fc_next;
    logic [32:0] pos_reg,    pos_next;
    logic [31:0] asm_reg,    asm_next;
    logic [30:0] size_reg,   size_next;
    logic [30:0] link_reg,   link_next;
    logic [30:0] left_reg,   left_next;
    logic [32:0] hstart_reg, hstart_next;
    logic [32:0] dstart_reg, dstart_next;
    logic [7:0]  flag_reg,   flag_next;
    logic [7:0]  len_reg,    len_next;
    logic [31:0] dt_reg,     dt_next;
    logic        gen_reg,    gen_next;
    logic [1:0]  var_reg,    var_next;
    logic [12:0] total_reg,  total_next;

    logic        proceed;
    logic        space_two;
    push_t       push;
    result_t     rec;
    result_t     fin;
    result_t     head;

    assign proceed  = in_valid_reg && space_two;
    assign in_ready = !in_valid_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                base_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= data_byte;
            final_reg <= is_final;
        end
    end

    // one byte step
    always_comb
    begin
        logic [32:0] pos_inc;
        logic [31:0] asm_shift;
        logic [7:0]  fc_inc;
        logic [7:0]  hlast;
        logic [32:0] data_rel;
        logic        arc_fail;
        logic        member_fail;
        logic        finish;
        status_t     fin_status;

        pos_inc     = pos_reg + 33'd1;
        asm_shift   = {byte_reg, asm_reg[31:8]};
        fc_inc      = fc_reg + 8'd1;
        hlast       = gen_reg ? MHDR_GEN3_LAST : MHDR_GEN1_LAST;
        data_rel    = (phase_reg == PH_SEP) ? pos_inc : dstart_reg;
        arc_fail    = 1'b0;
        member_fail = 1'b0;
        finish      = 1'b0;
        fin_status  = ST_TRUNCATED;

        phase_next  = phase_reg;
        err_next    = err_reg;
        fc_next     = fc_reg;
        pos_next    = pos_inc;
        asm_next    = asm_reg;
        size_next   = size_reg;
        link_next   = link_reg;
        left_next   = left_reg;
        hstart_next = hstart_reg;
        dstart_next = dstart_reg;
        flag_next   = flag_reg;
        len_next    = len_reg;
        dt_next     = dt_reg;
        gen_next    = gen_reg;
        var_next    = var_reg;
        total_next  = total_reg;
        push        = '0;

        case (phase_reg)
            PH_ARC:
            begin
                asm_next = asm_shift;
                fc_next  = fc_inc;
                if (fc_inc == MAGIC_LAST && asm_shift != ARC_MAGIC)
                begin
                    arc_fail = 1'b1;
                end
                else if (fc_inc == FORMAT_LAST)
                begin
                    if (asm_shift == FMT_GEN1)
                        gen_next = 1'b0;
                    else if (asm_shift == FMT_GEN3)
                        gen_next = 1'b1;
                    else
                        arc_fail = 1'b1;
                end
                else if (fc_inc == VARIANT_POS)
                begin
                    if (byte_reg == VARIANT_ONE || byte_reg == VARIANT_TWO)
                        var_next = byte_reg[1:0];
                    else
                        arc_fail = 1'b1;
                end
                else if (fc_inc == ARC_HDR_LEN)
                begin
                    if (asm_shift != '0)
                    begin
                        arc_fail = 1'b1;
                    end
                    else
                    begin
                        phase_next  = PH_MHDR;
                        fc_next     = '0;
                        hstart_next = ARC_HDR_START;
                        dt_next     = '0;
                    end
                end
                if (arc_fail)
                begin
                    gen_next   = 1'b0;
                    var_next   = '0;
                    phase_next = PH_ERR;
                    err_next   = ST_BAD_ARC;
                end
            end
            PH_MHDR:
            begin
                fc_next  = fc_inc;
                asm_next = asm_shift;
                if (fc_reg == MH_FLAG_POS)
                begin
                    flag_next = byte_reg;
                end
                else if (fc_reg == MH_SIZE_LAST)
                begin
                    if (asm_shift[31])
                        member_fail = 1'b1;
                    else
                        size_next = asm_shift[30:0];
                end
                else if (fc_reg == MH_LINK_LAST)
                begin
                    if (asm_shift[31])
                        member_fail = 1'b1;
                    else
                        link_next = asm_shift[30:0];
                end
                else if (gen_reg && fc_reg >= MH_DATE_FIRST && fc_reg <= MH_DATE_LAST)
                begin
                    dt_next = {byte_reg, dt_reg[31:8]};
                end
                if (!member_fail && fc_reg == hlast)
                begin
                    if (byte_reg == '0)
                    begin
                        member_fail = 1'b1;
                    end
                    else
                    begin
                        len_next   = byte_reg;
                        phase_next = PH_NAME;
                        fc_next    = '0;
                    end
                end
            end
            PH_NAME:
            begin
                if (fc_reg == '0 && byte_reg < NAME_MIN)
                begin
                    member_fail = 1'b1;
                end
                else
                begin
                    fc_next = fc_inc;
                    if (fc_inc >= len_reg)
                        phase_next = PH_SEP;
                end
            end
            PH_SEP:
            begin
                dstart_next = pos_inc;
                if (size_reg == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    left_next  = size_reg;
                    phase_next = PH_PAY;
                end
            end
            PH_PAY:
            begin
                left_next = left_reg - 31'd1;
                if (left_reg == 31'd1)
                    finish = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (member_fail)
        begin
            phase_next = PH_ERR;
            err_next   = ST_BAD_MEMBER;
        end

        rec.kind         = 1'b0;
        rec.status       = ST_OK;
        rec.member_index = total_reg;
        rec.hdr_offset   = {1'b0, base_reg} + hstart_reg;
        rec.pay_offset   = {1'b0, base_reg} + data_rel;
        rec.pay_size     = size_reg;
        rec.member_flags = flag_reg;
        rec.name_bytes   = len_reg;
        rec.stamp_date   = dt_reg[15:0];
        rec.stamp_time   = dt_reg[31:16];
        rec.gen_three    = gen_reg;
        rec.variant      = var_reg;

        if (finish)
        begin
            if (total_reg >= MAX_MEMBERS)
            begin
                phase_next = PH_ERR;
                err_next   = ST_TOO_MANY;
            end
            else
            begin
                push.rec_valid = 1'b1;
                total_next     = total_reg + 13'd1;
                if (link_reg == '0)
                begin
                    if (final_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        err_next   = ST_TRAILING;
                    end
                end
                else if ({2'b00, link_reg} != pos_inc)
                begin
                    phase_next = PH_ERR;
                    err_next   = ST_CHAIN;
                end
                else
                begin
                    phase_next  = PH_MHDR;
                    fc_next     = '0;
                    hstart_next = pos_inc;
                    dt_next     = '0;
                end
            end
        end

        if (phase_next == PH_ERR)
            fin_status = err_next;
        else if (phase_next == PH_DONE)
            fin_status = ST_OK;

        fin.kind         = 1'b1;
        fin.status       = fin_status;
        fin.member_index = total_next;
        fin.hdr_offset   = pos_inc;
        fin.pay_offset   = '0;
        fin.pay_size     = '0;
        fin.member_flags = '0;
        fin.name_bytes   = '0;
        fin.stamp_date   = '0;
        fin.stamp_time   = '0;
        fin.gen_three    = gen_next;
        fin.variant      = var_next;

        if (final_reg)
        begin
            push.fin_valid = 1'b1;
            phase_next     = PH_ARC;
            err_next       = ST_OK;
            fc_next        = '0;
            pos_next       = '0;
            asm_next       = '0;
            size_next      = '0;
            link_next      = '0;
            left_next      = '0;
            hstart_next    = '0;
            dstart_next    = '0;
            flag_next      = '0;
            len_next       = '0;
            dt_next        = '0;
            gen_next       = 1'b0;
            var_next       = '0;
            total_next     = '0;
        end

        if (!proceed)
            push = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ARC;
            err_reg    <= ST_OK;
            fc_reg     <= '0;
            pos_reg    <= '0;
            asm_reg    <= '0;
            size_reg   <= '0;
            link_reg   <= '0;
            left_reg   <= '0;
            hstart_reg <= '0;
            dstart_reg <= '0;
            flag_reg   <= '0;
            len_reg    <= '0;
            dt_reg     <= '0;
            gen_reg    <= 1'b0;
            var_reg    <= '0;
            total_reg  <= '0;
        end
        else if (proceed)
        begin
            phase_reg  <= phase_next;
            err_reg    <= err_next;
            fc_reg     <= fc_next;
            pos_reg    <= pos_next;
            asm_reg    <= asm_next;
            size_reg   <= size_next;
            link_reg   <= link_next;
            left_reg   <= left_next;
            hstart_reg <= hstart_next;
            dstart_reg <= dstart_next;
            flag_reg   <= flag_next;
            len_reg    <= len_next;
            dt_reg     <= dt_next;
            gen_reg    <= gen_next;
            var_reg    <= var_next;
            total_reg  <= total_next;
        end
    end

    acmcp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rec       (rec),
        .fin       (fin),
        .space_two (space_two),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign status       = head.status;
    assign member_index = head.member_index;
    assign hdr_offset   = head.hdr_offset;
    assign pay_offset   = head.pay_offset;
    assign pay_size     = head.pay_size;
    assign member_flags = head.member_flags;
    assign name_bytes   = head.name_bytes;
    assign stamp_date   = head.stamp_date;
    assign stamp_time   = head.stamp_time;
    assign gen_three    = head.gen_three;
    assign variant      = head.variant;

    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && final_reg) |=> (phase_reg == PH_ARC && total_reg == '0 && pos_reg == '0))
        else $error("parser did not restart after final byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proceed) |=> (in_valid_reg && $stable(byte_reg)
                                        && $stable(final_reg)))
        else $error("held input byte lost while stalled");

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_MEMBERS)
        else $error("member count above cap");

    a_variant_known: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ARC && !(phase_reg == PH_ERR && err_reg == ST_BAD_ARC))
        |-> (var_reg == 2'd1 || var_reg == 2'd2))
        else $error("member phase without accepted archive header");

endmodule

`default_nettype wire
